// ----- design/dls_pkg.sv -----
package dls_pkg;

	// Loss scale bounds in unsigned Q17.8: 1.0 and 65536.0.
	localparam int unsigned ScaleW = 25;
	localparam logic [ScaleW-1:0] SCALE_MIN = 25'd256;
	localparam logic [ScaleW-1:0] SCALE_MAX = 25'd16777216;

	localparam int unsigned FactorW = 16;
	localparam int unsigned IntervalW = 16;
	localparam int unsigned LimitW = 31;
	localparam int unsigned CountW = 17;
	localparam int unsigned TotalW = 32;

	localparam logic [CountW-1:0] COUNT_MAX = '1;
	localparam logic [TotalW-1:0] TOTAL_MAX = '1;
	// Good-step count never passes the largest interval plus one.
	localparam logic [CountW-1:0] GOOD_BOUND = 17'd65536;

	localparam int unsigned CfgIndexW = 3;
	localparam int unsigned CfgDataW = 31;
	localparam int unsigned SDataW = 40;
	localparam int unsigned MDataW = 80;

	// Field positions of the outgoing tdata word.
	localparam int unsigned M_FOUND_LSB = 0;
	localparam int unsigned M_SCALE_LSB = 1;
	localparam int unsigned M_TOTAL_LSB = 26;
	localparam int unsigned M_GOOD_LSB = 58;

	// Reset values of the configuration registers.
	localparam logic [ScaleW-1:0] INIT_SCALE_RST = 25'd16777216;
	localparam logic [FactorW-1:0] FACTOR_RST = 16'd512;
	localparam logic [IntervalW-1:0] INTERVAL_RST = 16'd2000;
	localparam logic [LimitW-1:0] LIMIT_RST = 31'd1176256512;

	typedef enum logic [1:0] {
		ACT_ELEMENT = 2'd0,
		ACT_UPDATE  = 2'd1,
		ACT_RESTART = 2'd2
	} action_t;

	typedef enum logic [CfgIndexW-1:0] {
		REG_ENABLED  = 3'd0,
		REG_DYNAMIC  = 3'd1,
		REG_INIT     = 3'd2,
		REG_FACTOR   = 3'd3,
		REG_INTERVAL = 3'd4,
		REG_LIMIT    = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [CountW-1:0] good_steps;
		logic [TotalW-1:0] overflow_total;
		logic [ScaleW-1:0] scale_value;
		logic              overflow_found;
	} result_t;

	// Clamps a widened scale into the legal Q17.8 range.
	function automatic logic [ScaleW-1:0] clamp_scale(input logic [32:0] s);
		logic [ScaleW-1:0] r;
		if (s < 33'(SCALE_MIN)) begin
			r = SCALE_MIN;
		end else if (s > 33'(SCALE_MAX)) begin
			r = SCALE_MAX;
		end else begin
			r = s[ScaleW-1:0];
		end
		return r;
	endfunction

endpackage

// ----- design/dynamic_loss_scaler_unit.sv -----
// A request is captured in the input register stage; its result is then registered in
// the output register, or in the skid while that waits. Throughput: one request per
// cycle while the skid is empty; the loss-scale recurrence (one 25 x 16 multiply, a
// shift and a clamp) closes combinationally on the state registers.
// Reset: arst_n low clears the pipeline and loads scale 65536.0, zero counts and the
// documented configuration defaults at once; no clearing pass is needed.
module dynamic_loss_scaler_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port: register index and data, no read-back.
	input  logic                              cfg_wr_en,
	input  logic [dls_pkg::CfgIndexW-1:0]     cfg_index,
	input  logic [dls_pkg::CfgDataW-1:0]      cfg_data,
	// Request stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata: grad_bits [31:0], overflow_flag [32], zero fill [39:33]
	input  logic [dls_pkg::SDataW-1:0]        s_tdata,
	// s_tuser: action [1:0]
	input  logic [1:0]                        s_tuser,
	input  logic                              s_tlast,
	// Result stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata: overflow_found [0], scale_value [25:1], overflow_total [57:26],
	//          good_steps [74:58], zero fill [79:75]
	output logic [dls_pkg::MDataW-1:0]        m_tdata,
	output logic                              m_tlast
);

	// Configuration registers.
	logic                            enabled_q;
	logic                            dynamic_q;
	logic [dls_pkg::ScaleW-1:0]      init_scale_q;
	logic [dls_pkg::FactorW-1:0]     factor_q;
	logic [dls_pkg::IntervalW-1:0]   interval_q;
	logic [dls_pkg::LimitW-1:0]      limit_q;

	// Scaler state.
	logic [dls_pkg::ScaleW-1:0]      scale_q;
	logic [dls_pkg::CountW-1:0]      good_q;
	logic                            seen_q;
	logic                            found_q;
	logic [dls_pkg::TotalW-1:0]      total_q;

	// Input register stage.
	logic                            valid_s1;
	dls_pkg::action_t                action_s1;
	logic [31:0]                     grad_s1;
	logic                            last_s1;
	logic                            ovf_s1;

	// Output register and skid stage.
	logic                            out_valid_q;
	dls_pkg::result_t                out_res_q;
	logic                            out_last_q;
	logic                            skid_valid_q;
	dls_pkg::result_t                skid_res_q;
	logic                            skid_last_q;

	// Next-state logic.
	logic                            advance;
	logic                            out_take;
	logic                            out_free;
	logic                            bad;
	logic [40:0]                     product;
	logic [32:0]                     scale_wide;
	logic [dls_pkg::CountW-1:0]      good_inc;
	logic [dls_pkg::ScaleW-1:0]      scale_n;
	logic [dls_pkg::CountW-1:0]      good_n;
	logic                            seen_n;
	logic                            found_n;
	logic [dls_pkg::TotalW-1:0]      total_n;
	logic                            done_n;
	dls_pkg::result_t                res_n;

	// The stage advances whenever the skid register is empty: the result then lands
	// either in the output register or, if that one is still waiting, in the skid.
	assign advance  = valid_s1 && !skid_valid_q;
	assign s_tready = !valid_s1 || !skid_valid_q;
	assign out_take = out_valid_q && m_tready;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q    <= 1'b1;
			dynamic_q    <= 1'b1;
			init_scale_q <= dls_pkg::INIT_SCALE_RST;
			factor_q     <= dls_pkg::FACTOR_RST;
			interval_q   <= dls_pkg::INTERVAL_RST;
			limit_q      <= dls_pkg::LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (dls_pkg::reg_index_t'(cfg_index))
				dls_pkg::REG_ENABLED:  enabled_q    <= cfg_data[0];
				dls_pkg::REG_DYNAMIC:  dynamic_q    <= cfg_data[0];
				dls_pkg::REG_INIT:     init_scale_q <= cfg_data[dls_pkg::ScaleW-1:0];
				dls_pkg::REG_FACTOR:   factor_q     <= cfg_data[dls_pkg::FactorW-1:0];
				dls_pkg::REG_INTERVAL: interval_q   <= cfg_data[dls_pkg::IntervalW-1:0];
				dls_pkg::REG_LIMIT:    limit_q      <= cfg_data[dls_pkg::LimitW-1:0];
				default: ;
			endcase
		end
	end

	// Input register: captured on every accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= dls_pkg::action_t'(s_tuser);
			grad_s1   <= s_tdata[31:0];
			ovf_s1    <= s_tdata[32];
			last_s1   <= s_tlast;
		end
	end

	// An element overflows when its exponent is all ones or its magnitude exceeds
	// the limit.
	assign bad = (&grad_s1[30:23]) || (grad_s1[30:0] > limit_q);

	// Growth product, Q17.8 times Q8.8, truncated back to Q17.8.
	assign product = 41'(scale_q) * 41'(factor_q);

	always_comb begin
		scale_n    = scale_q;
		good_n     = good_q;
		seen_n     = seen_q;
		found_n    = found_q;
		total_n    = total_q;
		done_n     = 1'b0;
		scale_wide = 33'(scale_q);
		good_inc   = (good_q != dls_pkg::COUNT_MAX) ? good_q + 17'd1 : good_q;
		case (action_s1)
			dls_pkg::ACT_ELEMENT: begin
				done_n = last_s1;
				if (enabled_q) begin
					// Only the first overflow of a check is counted.
					if (bad && !seen_q) begin
						seen_n  = 1'b1;
						found_n = 1'b1;
						if (total_q != dls_pkg::TOTAL_MAX) begin
							total_n = total_q + 32'd1;
						end
					end
					// The verdict settles on the last element of the check.
					if (last_s1) begin
						if (!seen_n) begin
							found_n = 1'b0;
						end
						seen_n = 1'b0;
					end
				end
			end
			dls_pkg::ACT_UPDATE: begin
				if (enabled_q && dynamic_q) begin
					if (ovf_s1) begin
						scale_wide = 33'(scale_q >> 1);
						good_n     = '0;
					end else if (good_inc > 17'(interval_q)) begin
						scale_wide = product[40:8];
						good_n     = '0;
					end else begin
						good_n = good_inc;
					end
					scale_n = dls_pkg::clamp_scale(scale_wide);
				end
			end
			dls_pkg::ACT_RESTART: begin
				scale_n = dls_pkg::clamp_scale(33'(init_scale_q));
				good_n  = '0;
				seen_n  = 1'b0;
				found_n = 1'b0;
				total_n = '0;
			end
			default: ;
		endcase
		res_n.overflow_found = found_n;
		res_n.scale_value    = scale_n;
		res_n.overflow_total = total_n;
		res_n.good_steps     = good_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= dls_pkg::SCALE_MAX;
			good_q  <= '0;
			seen_q  <= 1'b0;
			found_q <= 1'b0;
			total_q <= '0;
		end else if (advance) begin
			scale_q <= scale_n;
			good_q  <= good_n;
			seen_q  <= seen_n;
			found_q <= found_n;
			total_q <= total_n;
		end
	end

	// Output register with a skid behind it. The skid only fills when a new result
	// arrives while the output register still waits, and it drains first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= skid_valid_q || advance;
			end
			if (skid_valid_q && out_free) begin
				skid_valid_q <= 1'b0;
			end else if (advance && out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_res_q  <= skid_res_q;
				out_last_q <= skid_last_q;
			end else if (advance) begin
				out_res_q  <= res_n;
				out_last_q <= done_n;
			end
		end
		if (advance && out_valid_q && !out_take) begin
			skid_res_q  <= res_n;
			skid_last_q <= done_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {5'd0, out_res_q.good_steps, out_res_q.overflow_total,
		out_res_q.scale_value, out_res_q.overflow_found};

endmodule

// ----- design/dls_checker.sv -----
module dls_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dls_pkg::MDataW-1:0]    m_tdata,
	input logic                          m_tlast
);

	logic [dls_pkg::ScaleW-1:0] scale;
	logic [dls_pkg::TotalW-1:0] total;
	logic [dls_pkg::CountW-1:0] good;
	logic                       found;

	assign found = m_tdata[dls_pkg::M_FOUND_LSB];
	assign scale = m_tdata[dls_pkg::M_SCALE_LSB +: dls_pkg::ScaleW];
	assign total = m_tdata[dls_pkg::M_TOTAL_LSB +: dls_pkg::TotalW];
	assign good  = m_tdata[dls_pkg::M_GOOD_LSB +: dls_pkg::CountW];

	// A waiting result is neither withdrawn nor altered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// The clamp keeps the scale within 1.0 .. 65536.0.
	a_scale: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> scale >= dls_pkg::SCALE_MIN && scale <= dls_pkg::SCALE_MAX)
		else $error("scale out of range");

	// The good-step count stays within GOOD_BOUND, the largest interval plus one.
	a_good: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> good <= dls_pkg::GOOD_BOUND)
		else $error("good-step count beyond bound");

	// An overflow verdict is always backed by a counted overflow.
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && found |-> total != '0)
		else $error("overflow verdict without count");

endmodule

bind dynamic_loss_scaler_unit dls_checker u_dls_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
